>>> sv/deq_pkg.sv
package deq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;

   localparam int unsigned CMD_WIDTH    = 3;
   localparam int unsigned DATA_WIDTH   = 32;
   localparam int unsigned TOTAL_WIDTH  = 7;
   localparam int unsigned STATUS_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   localparam logic signed [DATA_WIDTH-1:0] EMPTY_VALUE = -32'sd1;

endpackage

>>> sv/deq_if.sv
interface deq_req_if;
   logic                                        valid;
   logic                                        ready;
   logic [deq_pkg::CMD_WIDTH-1:0]               cmd;
   logic signed [deq_pkg::DATA_WIDTH-1:0]       value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [deq_pkg::DATA_WIDTH-1:0]       front_value;
   logic signed [deq_pkg::DATA_WIDTH-1:0]       rear_value;
   logic                                        is_empty;
   logic                                        is_full;
   logic [deq_pkg::TOTAL_WIDTH-1:0]             entry_total;
   logic [deq_pkg::STATUS_WIDTH-1:0]            status;

   modport source (output valid, output front_value, output rear_value, output is_empty,
                   output is_full, output entry_total, output status, input ready);
   modport sink   (input valid, input front_value, input rear_value, input is_empty,
                   input is_full, input entry_total, input status, output ready);
endinterface

>>> sv/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit values kept in a ring memory of DEPTH entries.
// The req_port channel carries one command per transaction: push front, push rear,
// pop front, pop rear or query (unused codes behave as a query). The rsp_port
// channel returns exactly one transaction per command with the front and rear
// values after the command (-1 when empty), empty and full flags, the entry count
// and a status (ok, overflow on a push into a full queue, underflow on a pop of an
// empty queue; the queue is left unchanged in both error cases).
// The result is valid in the cycle after the command is accepted. The unit takes one
// command per cycle while the receiver takes each result; the ring memory does one
// write and two registered reads (new front, new rear) per command.
// The queue state itself is updated at the accepting edge.
// While the receiver stalls, the result register holds its transaction and the
// command channel is accepted only in a cycle in which the result is taken.
// Reset empties the queue at once; the ring memory is not cleared, since only
// entries that have been written are ever read.
module double_ended_queue_unit #(
   parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_port,
   deq_rsp_if.source  rsp_port
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned SW = CW + 1;
   localparam int unsigned DW = deq_pkg::DATA_WIDTH;

   localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [SW-1:0] WRAP_SPAN  = SW'(DEPTH);

   function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] pos);
      logic [SW-1:0] folded;
      folded = (pos >= WRAP_SPAN) ? pos - WRAP_SPAN : pos;
      return folded[AW-1:0];
   endfunction

   logic signed [DW-1:0] mem [DEPTH];

   logic [AW-1:0]          front_ff, front_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   out_valid_ff;
   logic signed [DW-1:0]   front_rd_ff, rear_rd_ff, value_ff;
   logic                   front_byp_ff, rear_byp_ff;
   deq_pkg::status_type    status_ff, status_in;

   logic                   accept;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rear_in;
   logic                   full, empty;
   logic [31:0]            total_wide;

   assign req_port.ready = !reset && (!out_valid_ff || rsp_port.ready);
   assign accept         = req_port.valid && req_port.ready;

   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      status_in = deq_pkg::ST_OK;
      unique case (req_port.cmd)
         deq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = deq_pkg::ST_OVERFLOW;
            end else begin
               front_in = (front_ff == '0) ? LAST_INDEX : front_ff - AW'(1);
               wr_addr  = front_in;
               wr_en    = accept;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::CMD_PUSH_REAR: begin
            if (full) begin
               status_in = deq_pkg::ST_OVERFLOW;
            end else begin
               wr_addr  = ring_wrap(SW'(front_ff) + SW'(count_ff));
               wr_en    = accept;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               status_in = deq_pkg::ST_UNDERFLOW;
            end else begin
               front_in = ring_wrap(SW'(front_ff) + SW'(1));
               count_in = count_ff - CW'(1);
            end
         end
         deq_pkg::CMD_POP_REAR: begin
            if (empty) begin
               status_in = deq_pkg::ST_UNDERFLOW;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
      // When the new count is zero this index is meaningless and goes unused.
      rear_in = ring_wrap(SW'(front_in) + SW'(count_in) - SW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff     <= front_in;
            count_ff     <= count_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_port.value;
      end
   end

   // The reads see the memory before this cycle's write, so a hit on the
   // written slot is flagged and the pushed value is taken instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         front_rd_ff  <= mem[front_in];
         rear_rd_ff   <= mem[rear_in];
         front_byp_ff <= wr_en && (wr_addr == front_in);
         rear_byp_ff  <= wr_en && (wr_addr == rear_in);
         value_ff     <= req_port.value;
         status_ff    <= status_in;
      end
   end

   assign total_wide = 32'(count_ff);

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.front_value = empty ? deq_pkg::EMPTY_VALUE
                               : (front_byp_ff ? value_ff : front_rd_ff);
   assign rsp_port.rear_value  = empty ? deq_pkg::EMPTY_VALUE
                               : (rear_byp_ff ? value_ff : rear_rd_ff);
   assign rsp_port.is_empty    = empty;
   assign rsp_port.is_full     = full;
   assign rsp_port.entry_total = total_wide[deq_pkg::TOTAL_WIDTH-1:0];
   assign rsp_port.status      = status_ff;

endmodule
